@@ sv/sha1_pkg.sv @@
// ----------------------------------------------------------------------------
// SHA-1 engine package
// Shared constants, types and round functions.
// ----------------------------------------------------------------------------
package sha1_pkg;

    localparam int unsigned BlockBytes = 64;
    localparam int unsigned Rounds     = 80;

    localparam logic [31:0] Iv0 = 32'h67452301;
    localparam logic [31:0] Iv1 = 32'hEFCDAB89;
    localparam logic [31:0] Iv2 = 32'h98BADCFE;
    localparam logic [31:0] Iv3 = 32'h10325476;
    localparam logic [31:0] Iv4 = 32'hC3D2E1F0;

    localparam logic [5:0] LenOffset = 6'd56;

    // datapath byte source
    typedef enum logic [1:0] {
        SRC_DATA = 2'd0,
        SRC_PAD  = 2'd1,
        SRC_ZERO = 2'd2,
        SRC_LEN  = 2'd3
    } t_src;

    typedef struct packed {
        logic       put;       // write one byte into the block buffer
        t_src       src;
        logic [7:0] data;
        logic       count;     // add 8 to the bit count
        logic       latch_len; // snapshot bit count for padding
        logic       start;     // start compression
        logic       init;      // reload IV and clear counts
    } t_cmd;

    typedef struct packed {
        logic       busy;      // compression or fold running
        logic [5:0] fill;
    } t_status;

    function automatic logic [31:0] round_k(input logic [6:0] rnd);
        logic [31:0] k;
        if (rnd < 7'd20)      k = 32'h5A827999;
        else if (rnd < 7'd40) k = 32'h6ED9EBA1;
        else if (rnd < 7'd60) k = 32'h8F1BBCDC;
        else                  k = 32'hCA62C1D6;
        return k;
    endfunction

    function automatic logic [31:0] round_f(input logic [6:0] rnd, input logic [31:0] b,
                                            input logic [31:0] c, input logic [31:0] d);
        logic [31:0] f;
        if (rnd < 7'd20)      f = (b & c) | (~b & d);
        else if (rnd < 7'd40) f = b ^ c ^ d;
        else if (rnd < 7'd60) f = (b & c) | (b & d) | (c & d);
        else                  f = b ^ c ^ d;
        return f;
    endfunction

endpackage

@@ sv/sha1_if.sv @@
// ----------------------------------------------------------------------------
// SHA-1 engine channel interfaces
// Valid/ready channels for message bytes and digest words.
// ----------------------------------------------------------------------------
interface sha1_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       byte_present;
    logic       end_of_message;
    modport source (output valid, data_byte, byte_present, end_of_message, input ready);
    modport sink   (input valid, data_byte, byte_present, end_of_message, output ready);
endinterface

interface sha1_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic [2:0]  word_number;
    logic        last_word;
    modport source (output valid, digest_word, word_number, last_word, input ready);
    modport sink   (input valid, digest_word, word_number, last_word, output ready);
endinterface

@@ sv/sha1_datapath.sv @@
// ----------------------------------------------------------------------------
// SHA-1 datapath
// Block words, bit count, message schedule and one round per cycle.
// ----------------------------------------------------------------------------
module sha1_datapath (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  sha1_pkg::t_cmd    i_cmd,
    input  logic [2:0]        i_word_sel,
    output sha1_pkg::t_status o_status,
    output logic [31:0]       o_hash_word
);

    logic [5:0]  r_fill;
    logic [63:0] r_bits;
    logic [63:0] r_len;
    logic [31:0] r_h [5];
    logic [31:0] r_w [16];
    logic [31:0] r_a, r_b, r_c, r_d, r_e;
    logic [6:0]  r_rnd;
    logic        r_busy;
    logic        r_fold;

    logic [7:0]  n_byte;
    logic [31:0] n_wnew;
    logic [31:0] n_wcur;
    logic [31:0] n_t;
    logic [2:0]  len_idx;

    assign len_idx = r_fill[2:0];

    always_comb begin
        case (i_cmd.src)
            sha1_pkg::SRC_DATA: n_byte = i_cmd.data;
            sha1_pkg::SRC_PAD:  n_byte = 8'h80;
            sha1_pkg::SRC_ZERO: n_byte = 8'h00;
            default:            n_byte = r_len[8'(7 - len_idx) * 8 +: 8];
        endcase
    end

    // schedule word for this round comes from the 16-word window
    assign n_wnew = {r_w[13] ^ r_w[8] ^ r_w[2] ^ r_w[0]};
    assign n_wcur = (r_rnd < 7'd16) ? r_w[0] : {n_wnew[30:0], n_wnew[31]};
    assign n_t    = {r_a[26:0], r_a[31:27]} + sha1_pkg::round_f(r_rnd, r_b, r_c, r_d)
                  + r_e + sha1_pkg::round_k(r_rnd) + n_wcur;

    // bytes land big-endian straight in the schedule window; no put while busy
    always_ff @(posedge i_clk) begin
        if (i_cmd.put) begin
            r_w[r_fill[5:2]][{~r_fill[1:0], 3'b000} +: 8] <= n_byte;
        end
        if (i_cmd.start) begin
            r_a <= r_h[0]; r_b <= r_h[1]; r_c <= r_h[2]; r_d <= r_h[3]; r_e <= r_h[4];
        end else if (r_busy) begin
            for (int i = 0; i < 15; i++) begin
                r_w[i] <= r_w[i + 1];
            end
            r_w[15] <= n_wcur;
            r_e <= r_d;
            r_d <= r_c;
            r_c <= {r_b[1:0], r_b[31:2]};
            r_b <= r_a;
            r_a <= n_t;
        end
        if (i_cmd.latch_len) begin
            r_len <= r_bits;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.init) begin
            r_fill <= '0;
            r_bits <= '0;
            r_busy <= 1'b0;
            r_fold <= 1'b0;
            r_rnd  <= '0;
            r_h[0] <= sha1_pkg::Iv0;
            r_h[1] <= sha1_pkg::Iv1;
            r_h[2] <= sha1_pkg::Iv2;
            r_h[3] <= sha1_pkg::Iv3;
            r_h[4] <= sha1_pkg::Iv4;
        end else begin
            r_fold <= 1'b0;
            if (i_cmd.put) begin
                r_fill <= r_fill + 6'd1;
            end
            if (i_cmd.count) begin
                r_bits <= r_bits + 64'd8;
            end
            if (i_cmd.start) begin
                r_busy <= 1'b1;
                r_rnd  <= '0;
            end else if (r_busy) begin
                r_rnd <= r_rnd + 7'd1;
                if (r_rnd == 7'(sha1_pkg::Rounds - 1)) begin
                    r_busy <= 1'b0;
                    r_fold <= 1'b1;
                end
            end
            if (r_fold) begin
                r_h[0] <= r_h[0] + r_a;
                r_h[1] <= r_h[1] + r_b;
                r_h[2] <= r_h[2] + r_c;
                r_h[3] <= r_h[3] + r_d;
                r_h[4] <= r_h[4] + r_e;
            end
        end
    end

    assign o_status.busy = r_busy | r_fold;
    assign o_status.fill = r_fill;
    assign o_hash_word   = r_h[(i_word_sel > 3'd4) ? 3'd4 : i_word_sel];

endmodule

@@ sv/sha1_ctrl.sv @@
// ----------------------------------------------------------------------------
// SHA-1 controller
// Sequences byte intake, padding, compression and digest output.
// ----------------------------------------------------------------------------
module sha1_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    sha1_in_if.sink           in_ch,
    sha1_out_if.source        out_ch,
    input  sha1_pkg::t_status i_status,
    input  logic [31:0]       i_hash_word,
    output sha1_pkg::t_cmd    o_cmd,
    output logic [2:0]        o_word_sel
);

    typedef enum logic [6:0] {
        ST_IDLE = 7'b0000001,
        ST_PAD  = 7'b0000010,
        ST_ZERO = 7'b0000100,
        ST_LEN  = 7'b0001000,
        ST_WAIT = 7'b0010000,
        ST_OUT  = 7'b0100000,
        ST_INIT = 7'b1000000
    } t_state;

    t_state      r_state, n_state;
    logic [2:0]  r_word, n_word;
    logic        r_ovalid, n_ovalid;
    logic [31:0] r_odata;
    logic        take;
    logic        put_last;

    assign take     = in_ch.valid && in_ch.ready;
    assign put_last = i_status.fill == 6'd63;
    assign in_ch.ready = (r_state == ST_IDLE) && !i_status.busy;

    always_comb begin
        n_state  = r_state;
        n_word   = r_word;
        n_ovalid = r_ovalid;
        o_cmd    = '0;
        o_cmd.src = sha1_pkg::SRC_DATA;
        o_cmd.data = in_ch.data_byte;
        if (out_ch.valid && out_ch.ready) begin
            n_ovalid = 1'b0;
        end
        unique case (r_state)
            ST_IDLE: begin
                if (take) begin
                    if (in_ch.byte_present) begin
                        o_cmd.put   = 1'b1;
                        o_cmd.count = 1'b1;
                        o_cmd.start = put_last;
                    end
                    if (in_ch.end_of_message) begin
                        n_state = ST_PAD;
                    end
                end
            end
            ST_PAD: begin
                if (!i_status.busy) begin
                    o_cmd.latch_len = 1'b1;
                    o_cmd.put       = 1'b1;
                    o_cmd.src       = sha1_pkg::SRC_PAD;
                    o_cmd.start     = put_last;
                    n_state         = ST_ZERO;
                end
            end
            ST_ZERO: begin
                if (!i_status.busy) begin
                    if (i_status.fill == sha1_pkg::LenOffset) begin
                        n_state = ST_LEN;
                    end else begin
                        o_cmd.put   = 1'b1;
                        o_cmd.src   = sha1_pkg::SRC_ZERO;
                        o_cmd.start = put_last;
                    end
                end
            end
            ST_LEN: begin
                o_cmd.put = 1'b1;
                o_cmd.src = sha1_pkg::SRC_LEN;
                if (put_last) begin
                    o_cmd.start = 1'b1;
                    n_state     = ST_WAIT;
                end
            end
            ST_WAIT: begin
                if (!i_status.busy) begin
                    n_word  = '0;
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!r_ovalid || (out_ch.valid && out_ch.ready)) begin
                    n_ovalid = 1'b1;
                    n_word   = r_word + 3'd1;
                    if (r_word == 3'd4) begin
                        n_state = ST_INIT;
                    end
                end
            end
            ST_INIT: begin
                o_cmd.init = 1'b1;
                n_state    = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_word   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_word   <= n_word;
            r_ovalid <= n_ovalid;
        end
    end

    // output register: number is one behind the issue counter
    logic [2:0] r_onum;
    always_ff @(posedge i_clk) begin
        if (r_state == ST_OUT && (!r_ovalid || (out_ch.valid && out_ch.ready))) begin
            r_odata <= i_hash_word;
            r_onum  <= r_word;
        end
    end

    assign o_word_sel          = r_word;
    assign out_ch.valid        = r_ovalid;
    assign out_ch.digest_word  = r_odata;
    assign out_ch.word_number  = r_onum;
    assign out_ch.last_word    = r_onum == 3'd4;

endmodule

@@ sv/sha1_hash_engine.sv @@
// ----------------------------------------------------------------------------
// SHA-1 hash engine
// Byte-serial SHA-1 with digest output as five 32-bit words.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one transaction per message byte (byte_present) and marks
//   the last transaction with end_of_message; an end transaction without a
//   byte finalizes the message, so an empty message is allowed.
//   out_ch returns five transactions per message: digest words H0..H4,
//   big-endian, word_number 0..4, last_word set on the fifth.
// Throughput: bytes are taken back to back; every 64th byte starts the
//   compression, 80 rounds at one round per cycle and then a fold into the
//   chaining value, during which input is held off. The round unit sets the rate.
// Finishing: after the end transaction, padding writes one byte per cycle
//   while no compression runs and takes one or two compressions, then the
//   five words follow one per cycle when the receiver is ready.
// Reset: loads the initial chaining value and clears counts; no clearing pass.
// Stall: a stalled receiver holds the current word in the output register and
//   the digest sequencing waits; only the fifth word may still wait there
//   while bytes of the next message are taken.
// ----------------------------------------------------------------------------
module sha1_hash_engine (
    input  logic        i_clk,
    input  logic        i_rst_n,
    sha1_in_if.sink     in_ch,
    sha1_out_if.source  out_ch
);

    sha1_pkg::t_cmd    cmd;
    sha1_pkg::t_status status;
    logic [2:0]        word_sel;
    logic [31:0]       hash_word;

    sha1_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .in_ch       (in_ch),
        .out_ch      (out_ch),
        .i_status    (status),
        .i_hash_word (hash_word),
        .o_cmd       (cmd),
        .o_word_sel  (word_sel)
    );

    sha1_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_word_sel  (word_sel),
        .o_status    (status),
        .o_hash_word (hash_word)
    );

endmodule
